/* design/mtlu_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and SHA-256 constants for the Merkle tree leaf update block.
// Depends on nothing; used by mtlu_sha_core and merkle_tree_leaf_update_top.
package mtlu_pkg;

    localparam int DIGEST_W = 256;
    localparam int BLOCK_W  = 2 * DIGEST_W;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_GROW = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BEYOND   = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;

    // Padding block for a 64-byte message: 0x80 marker, zeros, bit length 512.
    localparam logic [BLOCK_W-1:0] PAD_BLOCK = {32'h80000000, 448'd0, 32'd512};

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic start;   // load a block and begin 64 rounds
        logic init;    // start from the IV rather than the chained state
    } sha_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;    // one-cycle pulse, digest valid
    } sha_sts_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* design/merkle_tree_leaf_update_top.sv */
`timescale 1ns / 1ps
// Merkle tree leaf update: node store, sequencer and one shared SHA-256 unit.
// Depends on mtlu_pkg, mtlu_ram and mtlu_sha_core.
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+-------------------
//  input   | s_op s_position s_target_leaves s_digest| in        | s_valid / s_ready
//  result  | m_root_w0..3 m_leaves_now m_status      | out       | m_valid / m_ready
//
// Every hashed node costs two node reads, two SHA-256 compressions of 64 rounds
// each in the shared core, and one write. A set-leaf transfer hashes up to one
// level per tree level plus one growth, a grow transfer one node per doubling.
// After reset the node store is swept to zero, all 2 * LEAF_CAPACITY words,
// with s_ready low. One item is in work at a time; s_ready is low from
// acceptance until the result transfer completes, and m_valid holds until taken.
module merkle_tree_leaf_update_top #(
    parameter int LEAF_CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [9:0]  s_position,
    input  logic [10:0] s_target_leaves,
    input  logic [63:0] s_digest_w0,
    input  logic [63:0] s_digest_w1,
    input  logic [63:0] s_digest_w2,
    input  logic [63:0] s_digest_w3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_root_w0,
    output logic [63:0] m_root_w1,
    output logic [63:0] m_root_w2,
    output logic [63:0] m_root_w3,
    output logic [10:0] m_leaves_now,
    output logic [1:0]  m_status
);

    // Nodes are stored level by level, leaves first, so growth moves nothing.
    localparam int NODES = 2 * LEAF_CAPACITY;
    localparam int AW    = $clog2(NODES);
    localparam int CNTW  = $clog2(LEAF_CAPACITY + 1);
    localparam int XW0   = $clog2(2 * LEAF_CAPACITY + 1);
    localparam int XW    = (XW0 > 11) ? XW0 : 11;
    localparam int HW    = $clog2($clog2(LEAF_CAPACITY) + 2);
    localparam int DW    = mtlu_pkg::DIGEST_W;
    localparam logic [XW-1:0] CAP_X   = XW'(LEAF_CAPACITY);
    localparam logic [AW:0]   NODES_V = (AW + 1)'(NODES);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_GROW  = 4'd3;
    localparam logic [3:0] S_WLEAF = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_RDL   = 4'd6;
    localparam logic [3:0] S_RDR   = 4'd7;
    localparam logic [3:0] S_RDW   = 4'd8;
    localparam logic [3:0] S_H1    = 4'd9;
    localparam logic [3:0] S_H1W   = 4'd10;
    localparam logic [3:0] S_H2W   = 4'd11;
    localparam logic [3:0] S_WR    = 4'd12;
    localparam logic [3:0] S_RDT   = 4'd13;
    localparam logic [3:0] S_RDTW  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    // Word address of node (level, index); the sum stays below twice the store size.
    function automatic logic [AW-1:0] node_addr(input logic [HW-1:0] lvl,
                                                input logic [AW-1:0] idx);
        logic [AW:0] off;
        off = NODES_V - (NODES_V >> lvl) + {1'b0, idx};
        if (off >= NODES_V) begin
            off = off - NODES_V;
        end
        return off[AW-1:0];
    endfunction

    logic [3:0]      state_reg, state_next;
    logic [AW:0]     clr_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [HW-1:0]   h_reg;
    logic [HW-1:0]   lvl_reg;
    logic [AW-1:0]   idx_reg;
    logic [XW-1:0]   s_reg;
    logic            grow_reg;
    logic            op_reg;
    logic [1:0]      status_reg;
    logic [AW-1:0]   pos_reg;
    logic [10:0]     tgt_reg;
    logic [DW-1:0]   leaf_reg, left_reg, right_reg, root_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [DW-1:0]   ram_wdata, ram_rdata;

    mtlu_pkg::sha_ctl_t sha_ctl;
    mtlu_pkg::sha_sts_t sha_sts;
    logic [mtlu_pkg::BLOCK_W-1:0] sha_block;
    logic [DW-1:0]   sha_digest;

    logic [XW-1:0]   cnt_x, pos_x, tgt_x, dbl_x;
    logic [AW-1:0]   child_l;

    assign cnt_x   = XW'(cnt_reg);
    assign pos_x   = XW'(s_position);
    assign tgt_x   = XW'(tgt_reg);
    assign dbl_x   = (cnt_reg == '0) ? XW'(1) : (cnt_x << 1);
    assign child_l = {idx_reg[AW-2:0], 1'b0};

    mtlu_ram #(
        .WIDTH(DW),
        .DEPTH(NODES)
    ) u_nodes (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    mtlu_sha_core u_sha (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (sha_ctl),
        .block_in(sha_block),
        .sts     (sha_sts),
        .digest  (sha_digest)
    );

    // Node store ports: sweep writes, leaf writes and hashed parents share one write port.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = clr_reg[AW-1:0];
        ram_wdata = '0;
        case (state_reg)
            S_CLR: begin
                ram_we = 1'b1;
            end
            S_WLEAF: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = leaf_reg;
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_waddr = node_addr(lvl_reg, idx_reg);
                ram_wdata = sha_digest;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            S_RDL:   ram_raddr = node_addr(lvl_reg - HW'(1), child_l);
            S_RDR:   ram_raddr = node_addr(lvl_reg - HW'(1), child_l | AW'(1));
            default: ram_raddr = node_addr(h_reg, '0);
        endcase
    end

    // The first block carries both children; the second is the fixed padding block.
    always_comb begin
        sha_ctl.start = 1'b0;
        sha_ctl.init  = 1'b1;
        sha_block     = {left_reg, right_reg};
        if (state_reg == S_H1) begin
            sha_ctl.start = 1'b1;
        end else if (state_reg == S_H1W && sha_sts.done) begin
            sha_ctl.start = 1'b1;
            sha_ctl.init  = 1'b0;
            sha_block     = mtlu_pkg::PAD_BLOCK;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:   if (clr_reg == NODES_V - (AW + 1)'(1)) state_next = S_IDLE;
            S_IDLE: begin
                if (s_valid) begin
                    if (s_op == mtlu_pkg::OP_GROW) begin
                        state_next = S_CHK;
                    end else if (pos_x > cnt_x) begin
                        state_next = S_RDT;
                    end else if (pos_x == cnt_x && dbl_x > CAP_X) begin
                        state_next = S_RDT;
                    end else if (pos_x == cnt_x && cnt_reg != '0) begin
                        state_next = S_RDL;
                    end else begin
                        state_next = S_WLEAF;
                    end
                end
            end
            S_CHK: begin
                if (!(s_reg < tgt_x && s_reg <= CAP_X)) begin
                    state_next = (s_reg > CAP_X) ? S_RDT : S_GROW;
                end
            end
            S_GROW: begin
                if (cnt_x >= tgt_x) begin
                    state_next = S_RDT;
                end else if (cnt_reg != '0) begin
                    state_next = S_RDL;
                end
            end
            S_WLEAF: state_next = S_UPD;
            S_UPD:   state_next = (lvl_reg > h_reg) ? S_RDT : S_RDL;
            S_RDL:   state_next = S_RDR;
            S_RDR:   state_next = S_RDW;
            S_RDW:   state_next = S_H1;
            S_H1:    state_next = S_H1W;
            S_H1W:   if (sha_sts.done) state_next = S_H2W;
            S_H2W:   if (sha_sts.done) state_next = S_WR;
            S_WR: begin
                if (grow_reg) begin
                    state_next = (op_reg == mtlu_pkg::OP_GROW) ? S_GROW : S_WLEAF;
                end else begin
                    state_next = S_UPD;
                end
            end
            S_RDT:   state_next = S_RDTW;
            S_RDTW:  state_next = S_OUT;
            S_OUT:   if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            h_reg      <= '0;
            lvl_reg    <= '0;
            idx_reg    <= '0;
            s_reg      <= '0;
            grow_reg   <= 1'b0;
            op_reg     <= mtlu_pkg::OP_SET;
            status_reg <= mtlu_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_CLR: clr_reg <= clr_reg + (AW + 1)'(1);
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= s_op;
                        status_reg <= mtlu_pkg::ST_OK;
                        s_reg      <= cnt_x;
                        if (s_op == mtlu_pkg::OP_SET) begin
                            if (pos_x > cnt_x) begin
                                status_reg <= mtlu_pkg::ST_BEYOND;
                            end else if (pos_x == cnt_x && dbl_x > CAP_X) begin
                                status_reg <= mtlu_pkg::ST_CAPACITY;
                            end else if (pos_x == cnt_x && cnt_reg == '0) begin
                                cnt_reg <= CNTW'(1);
                                h_reg   <= '0;
                            end else if (pos_x == cnt_x) begin
                                lvl_reg  <= h_reg + HW'(1);
                                idx_reg  <= '0;
                                grow_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_CHK: begin
                    if (s_reg < tgt_x && s_reg <= CAP_X) begin
                        s_reg <= (s_reg == '0) ? XW'(1) : (s_reg << 1);
                    end else if (s_reg > CAP_X) begin
                        status_reg <= mtlu_pkg::ST_CAPACITY;
                    end
                end
                S_GROW: begin
                    if (cnt_x < tgt_x) begin
                        if (cnt_reg == '0) begin
                            cnt_reg <= CNTW'(1);
                            h_reg   <= '0;
                        end else begin
                            lvl_reg  <= h_reg + HW'(1);
                            idx_reg  <= '0;
                            grow_reg <= 1'b1;
                        end
                    end
                end
                S_WLEAF: begin
                    lvl_reg <= HW'(1);
                    idx_reg <= pos_reg >> 1;
                end
                S_WR: begin
                    if (grow_reg) begin
                        grow_reg <= 1'b0;
                        h_reg    <= h_reg + HW'(1);
                        cnt_reg  <= cnt_reg << 1;
                    end else begin
                        lvl_reg <= lvl_reg + HW'(1);
                        idx_reg <= idx_reg >> 1;
                    end
                end
                default: begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            pos_reg  <= AW'(s_position);
            tgt_reg  <= s_target_leaves;
            leaf_reg <= {s_digest_w0, s_digest_w1, s_digest_w2, s_digest_w3};
        end
        if (state_reg == S_RDR) begin
            left_reg <= ram_rdata;
        end
        if (state_reg == S_RDW) begin
            right_reg <= ram_rdata;
        end
        if (state_reg == S_RDTW) begin
            root_reg <= ram_rdata;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_OUT);
    assign m_root_w0    = root_reg[255:192];
    assign m_root_w1    = root_reg[191:128];
    assign m_root_w2    = root_reg[127:64];
    assign m_root_w3    = root_reg[63:0];
    assign m_leaves_now = 11'(cnt_reg);
    assign m_status     = status_reg;

    // The leaf count goes from zero to one and then only doubles, so it stays zero or a power of two.
    a_count_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cnt_reg) <= 1)
        else $error("leaf count is not a power of two");

    // The hash core is started only while idle.
    a_sha_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sha_ctl.start |-> !sha_sts.busy)
        else $error("hash core started while busy");

    // A failed item leaves the leaf count as it was.
    a_err_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RDT && status_reg != mtlu_pkg::ST_OK) |-> $stable(cnt_reg))
        else $error("leaf count changed on a rejected item");

    // Input and result sides never handshake in the same cycle.
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready and result valid together");

endmodule

/* design/mtlu_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mtlu_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/mtlu_sha_core.sv */
`timescale 1ns / 1ps
// SHA-256 compression unit, one round per clock, with chained hash state.
// Depends on mtlu_pkg.
module mtlu_sha_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mtlu_pkg::sha_ctl_t                ctl,
    input  logic [mtlu_pkg::BLOCK_W-1:0]      block_in,
    output mtlu_pkg::sha_sts_t                sts,
    output logic [mtlu_pkg::DIGEST_W-1:0]     digest
);

    logic        busy_reg, fin_reg, done_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];

    logic [31:0] w_new, t1, t2, s0, s1, e1, a0, ch, mj;

    always_comb begin
        s0 = mtlu_pkg::rotr(w_reg[1], 7) ^ mtlu_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = mtlu_pkg::rotr(w_reg[14], 17) ^ mtlu_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        e1 = mtlu_pkg::rotr(v_reg[4], 6) ^ mtlu_pkg::rotr(v_reg[4], 11)
             ^ mtlu_pkg::rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + e1 + ch + mtlu_pkg::SHA_K[rnd_reg] + w_reg[0];
        a0 = mtlu_pkg::rotr(v_reg[0], 2) ^ mtlu_pkg::rotr(v_reg[0], 13)
             ^ mtlu_pkg::rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = a0 + mj;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end else if (busy_reg) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= ctl.init ? mtlu_pkg::SHA_IV[i] : h_reg[i];
                v_reg[i] <= ctl.init ? mtlu_pkg::SHA_IV[i] : h_reg[i];
            end
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= block_in[mtlu_pkg::BLOCK_W-1-32*i -: 32];
            end
        end else if (busy_reg) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end else if (fin_reg) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    assign sts.busy = busy_reg | fin_reg;
    assign sts.done = done_reg;
    assign digest = {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                     h_reg[4], h_reg[5], h_reg[6], h_reg[7]};

endmodule
